/* hw/rtl/cfl_pkg.sv */
`default_nettype none
package cfl_pkg;

    typedef struct packed {
        logic signed [31:0] velocity_x;
        logic signed [31:0] velocity_y;
        logic signed [31:0] velocity_z;
        logic [31:0]        eddy_viscosity;
        logic [31:0]        dx_size;
        logic [31:0]        dy_size;
        logic [31:0]        dz_size;
        logic               is_obstacle;
        logic               sweep_last;
    } t_in_req;

    typedef struct packed {
        logic [31:0] min_step;
        logic        sweep_done;
    } t_out_req;

    localparam logic [1:0] REG_INV_RE    = 2'd0;
    localparam logic [1:0] REG_USER_STEP = 2'd1;
    localparam logic [1:0] REG_DIMS      = 2'd2;

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    // Divider control between sequencer and divider.
    typedef struct packed {
        logic        start;
        logic [96:0] num;
        logic [63:0] den;
    } t_div_cmd;

    typedef struct packed {
        logic        done;
        logic [96:0] quo;
    } t_div_rsp;

endpackage
`default_nettype wire

/* hw/rtl/cfl_divider.sv */
`default_nettype none
// Restoring radix-2 divider, one quotient bit per cycle.
module cfl_divider (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cfl_pkg::t_div_cmd i_cmd,
    output cfl_pkg::t_div_rsp      o_rsp
);
    import cfl_pkg::*;

    logic [96:0] r_quo;
    logic [64:0] r_rem;
    logic [63:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] n_shift;
    logic [65:0] n_diff;

    always_comb begin
        n_shift = {r_rem[63:0], r_quo[96]};
        n_diff  = {1'b0, n_shift} - {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
                r_quo  <= i_cmd.num;
                r_rem  <= '0;
                r_den  <= i_cmd.den;
            end else if (r_busy) begin
                if (!n_diff[65]) begin
                    r_rem <= n_diff[64:0];
                    r_quo <= {r_quo[95:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_quo <= {r_quo[95:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd96) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule
`default_nettype wire

/* hw/rtl/cfl_mul32.sv */
`default_nettype none
// Registered 32x32 multiplier used for squares and for the viscosity product.
module cfl_mul32 (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic [63:0]      o_p
);
    logic [63:0] r_p;
    always_ff @(posedge i_clk) begin
        r_p <= {32'd0, i_a} * {32'd0, i_b};
    end
    assign o_p = r_p;
endmodule
`default_nettype wire

/* hw/rtl/cfl_diffusion_timestep_min.sv */
// Work per request: up to five serial divisions in 2D and seven in 3D. A zero spacing
// or velocity skips its division. An obstacle request skips all divisions and goes
// straight from idle to the S_FIN and S_OUT states.
// Throughput: one request at a time; the input is stalled until the result has been
// handed to the output register. Rate is set by the shared serial divider.
// Reset (synchronous, active low) restores the state and configuration registers to their
// defaults and sets the running minimum to the maximum.
`default_nettype none
module cfl_diffusion_timestep_min (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire cfl_pkg::t_in_req  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output cfl_pkg::t_out_req      o_out_data,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [31:0]       i_cfg_data
);
    import cfl_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ    = 4'd1;  // multiply d*d for axis r_ax
    localparam logic [3:0] S_SQW   = 4'd2;
    localparam logic [3:0] S_INV   = 4'd3;  // wait divider for inverse square
    localparam logic [3:0] S_VM    = 4'd4;  // visc * factor, in 32-bit parts
    localparam logic [3:0] S_VMW   = 4'd5;
    localparam logic [3:0] S_DIFF  = 4'd6;
    localparam logic [3:0] S_ADV   = 4'd7;
    localparam logic [3:0] S_ADVW  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]  r_state;
    t_in_req     r_req;
    logic [31:0] r_inv_re, r_user, r_min, r_cand, r_diff, r_adv_x, r_adv_y, r_adv_z;
    logic [1:0]  r_dims, r_ax, r_vpart;
    logic [65:0] r_fac;
    logic [32:0] r_visc;
    logic [97:0] r_prod;
    logic        r_ovf;
    logic        r_ovalid;
    t_out_req    r_out;
    t_div_cmd    n_cmd;
    t_div_rsp    w_rsp;
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_p;
    logic [31:0] ax_d, ax_m, fac_part;
    logic        three;
    logic [31:0] ux, uy, uz, cmin;
    logic [31:0] sat_q;

    function automatic logic [31:0] mag(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    assign three = (r_dims == 2'd3);
    assign ux = mag(r_req.velocity_x);
    assign uy = mag(r_req.velocity_y);
    assign uz = mag(r_req.velocity_z);
    assign sat_q = (w_rsp.quo[96:32] != '0) ? SAT32 : w_rsp.quo[31:0];

    always_comb begin
        case (r_ax)
            2'd0:    begin ax_d = r_req.dx_size; ax_m = ux; end
            2'd1:    begin ax_d = r_req.dy_size; ax_m = uy; end
            default: begin ax_d = r_req.dz_size; ax_m = uz; end
        endcase
    end

    always_comb begin
        case (r_vpart)
            2'd0:    fac_part = r_fac[31:0];
            2'd1:    fac_part = r_fac[63:32];
            default: fac_part = {30'd0, r_fac[65:64]};
        endcase
    end

    assign w_ma = (r_state == S_VM) ? fac_part : ax_d;
    assign w_mb = (r_state == S_VM) ? r_visc[31:0] : ax_d;

    cfl_mul32 u_mul (.i_clk(i_clk), .i_a(w_ma), .i_b(w_mb), .o_p(w_p));
    cfl_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(n_cmd), .o_rsp(w_rsp));

    always_comb begin
        n_cmd = '0;
        if (r_state == S_SQW) begin
            n_cmd.start = (ax_d != '0);
            n_cmd.num   = 97'd1 << 48;
            n_cmd.den   = w_p;
        end else if (r_state == S_DIFF) begin
            n_cmd.start = !r_ovf && (r_prod != '0);
            n_cmd.num   = 97'd1 << 47;
            n_cmd.den   = r_prod[63:0];
        end else if (r_state == S_ADV) begin
            n_cmd.start = (ax_m != '0);
            n_cmd.num   = {49'd0, ax_d, 16'd0};
            n_cmd.den   = {32'd0, ax_m};
        end
    end

    always_comb begin
        cmin = r_cand;
        if (ux != '0 && uy != '0) begin
            if (r_adv_x < cmin) cmin = r_adv_x;
            if (r_adv_y < cmin) cmin = r_adv_y;
        end
        if (r_diff < cmin) cmin = r_diff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_inv_re <= 32'd655;
            r_user   <= 32'd65536;
            r_dims   <= 2'd2;
            r_min    <= SAT32;
            r_ovalid <= 1'b0;
            r_ovf    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_INV_RE:    r_inv_re <= i_cfg_data;
                    REG_USER_STEP: r_user   <= i_cfg_data;
                    REG_DIMS:      r_dims   <= i_cfg_data[1:0];
                    default:       ;
                endcase
            end
            if (r_ovalid && !i_out_stall && r_state != S_OUT) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req  <= i_in_data;
                        r_visc <= {1'b0, i_in_data.eddy_viscosity} + {1'b0, r_inv_re};
                        r_fac  <= '0;
                        r_ax   <= 2'd0;
                        r_state <= i_in_data.is_obstacle ? S_FIN : S_SQ;
                    end
                end
                S_SQ:  r_state <= S_SQW;
                S_SQW: begin
                    if (ax_d == '0) begin
                        r_fac <= r_fac + {34'd0, SAT32};
                        r_state <= S_INV;
                    end else r_state <= S_INV;
                end
                S_INV: begin
                    if (ax_d == '0 || w_rsp.done) begin
                        if (ax_d != '0) r_fac <= r_fac + {34'd0, sat_q};
                        if (r_ax == 2'd0 || (r_ax == 2'd1 && three)) begin
                            r_ax <= r_ax + 2'd1;
                            r_state <= S_SQ;
                        end else begin
                            r_vpart <= 2'd0;
                            r_prod  <= '0;
                            r_state <= S_VM;
                        end
                    end
                end
                S_VM: r_state <= S_VMW;
                S_VMW: begin
                    // Product of visc (33 bits) and factor (66 bits) built from parts.
                    case (r_vpart)
                        2'd0: r_prod <= r_prod + {34'd0, w_p}
                                      + (r_visc[32] ? {r_fac, 32'd0} : 98'd0);
                        2'd1: r_prod <= r_prod + {2'd0, w_p, 32'd0};
                        default: r_prod <= r_prod + {w_p[33:0], 64'd0};
                    endcase
                    if (r_vpart == 2'd2) r_state <= S_DIFF;
                    else begin
                        r_vpart <= r_vpart + 2'd1;
                        r_state <= S_VM;
                    end
                end
                S_DIFF: begin
                    if (r_visc == '0 || r_fac == '0 || r_prod[97:64] != '0 ||
                        w_rsp.done) begin
                        r_ovf <= 1'b0;
                        r_ax <= 2'd0;
                        r_state <= S_ADV;
                        if (r_visc == '0 || r_fac == '0) r_diff <= SAT32;
                        else if (r_prod[97:64] != '0) r_diff <= '0;
                        else r_diff <= sat_q;
                    end else r_ovf <= 1'b1;
                end
                S_ADV: r_state <= S_ADVW;
                S_ADVW: begin
                    if (ax_m == '0 || w_rsp.done) begin
                        case (r_ax)
                            2'd0:    r_adv_x <= sat_q;
                            2'd1:    r_adv_y <= sat_q;
                            default: r_adv_z <= sat_q;
                        endcase
                        if (r_ax == 2'd0 || (r_ax == 2'd1 && three)) begin
                            r_ax <= r_ax + 2'd1;
                            r_state <= S_ADV;
                        end else r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_req.is_obstacle) begin
                        if (cmin < r_min) r_min <= cmin;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_out.min_step   <= r_min;
                        r_out.sweep_done <= r_req.sweep_last;
                        r_ovalid <= 1'b1;
                        if (r_req.sweep_last) r_min <= SAT32;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Seed candidate for the final compare.
    always_comb begin
        r_cand = r_user;
        if (three) begin
            if (uz != '0) r_cand = r_adv_z;
        end else if (ux != '0) r_cand = r_adv_x;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

/* hw/rtl/cfl_checker.sv */
`default_nettype none
module cfl_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_stall,
    input wire logic             o_out_valid,
    input wire logic             i_out_stall,
    input wire cfl_pkg::t_out_req o_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while busy");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");
endmodule
bind cfl_diffusion_timestep_min cfl_checker u_chk (.*);
`default_nettype wire

/* sim/cfl_diffusion_timestep_min_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module cfl_diffusion_timestep_min_tb;
    import cfl_pkg::*;

    localparam int unsigned LONG_HOLD_CYCLES = 3000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_req     i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_req    o_out_data;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    cfl_diffusion_timestep_min u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state and configuration.
    logic [31:0] pred_inv_re;
    logic [31:0] pred_user_step;
    logic [1:0]  pred_dims;
    logic [31:0] pred_running_min;

    t_in_req  cell_queue[$];
    t_out_req step_queue[$];
    int unsigned error_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned recv_hold_left;
    bit          send_paused;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] inv_square(input logic [31:0] d);
        logic [63:0] sq;
        logic [63:0] q;
        if (d == 0) return 64'(SAT32);
        sq = 64'(d) * 64'(d);
        q = (64'd1 << 48) / sq;
        return (q > 64'(SAT32)) ? 64'(SAT32) : q;
    endfunction

    function automatic logic [63:0] speed_mag(input logic [31:0] raw);
        if (raw[31]) return 64'h1_0000_0000 - 64'(raw);
        return 64'(raw);
    endfunction

    function automatic logic [63:0] advect_limit(input logic [31:0] d, input logic [63:0] mag);
        logic [63:0] q;
        q = (64'(d) << 16) / mag;
        return (q > 64'(SAT32)) ? 64'(SAT32) : q;
    endfunction

    function automatic logic [63:0] min2(input logic [63:0] a, input logic [63:0] b);
        return (a < b) ? a : b;
    endfunction

    // Works out the running minimum after one cell and the result it shows.
    function automatic t_out_req predict_min_step(input t_in_req c);
        t_out_req    r;
        logic [63:0] ux, uy, uz, visc, fac, diff, cand;
        logic [127:0] prod;
        bit          three;
        ux = speed_mag(c.velocity_x);
        uy = speed_mag(c.velocity_y);
        uz = speed_mag(c.velocity_z);
        three = (pred_dims == 2'd3);
        if (!c.is_obstacle) begin
            visc = 64'(c.eddy_viscosity) + 64'(pred_inv_re);
            fac = inv_square(c.dx_size) + inv_square(c.dy_size);
            if (three) fac += inv_square(c.dz_size);
            prod = 128'(visc) * 128'(fac);
            if (visc == 0 || fac == 0) diff = 64'(SAT32);
            else if (prod[127:64] != 0) diff = 0;
            else diff = min2((64'd1 << 47) / prod[63:0], 64'(SAT32));
            cand = 64'(pred_user_step);
            if (three) begin
                if (uz != 0) cand = advect_limit(c.dz_size, uz);
            end else if (ux != 0) begin
                cand = advect_limit(c.dx_size, ux);
            end
            if (ux != 0 && uy != 0)
                cand = min2(diff, min2(cand, min2(advect_limit(c.dx_size, ux),
                                                  advect_limit(c.dy_size, uy))));
            else
                cand = min2(diff, cand);
            if (cand < 64'(pred_running_min)) pred_running_min = cand[31:0];
        end
        r.min_step = pred_running_min;
        r.sweep_done = c.sweep_last;
        if (c.sweep_last) pred_running_min = SAT32;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Driver: the expectation is recorded when the request is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                step_queue.push_back(predict_min_step(i_in_data));
            if (!i_in_valid || !o_in_stall) begin
                if (cell_queue.size() != 0 && !send_paused &&
                    $urandom_range(99) >= send_idle_pct) begin
                    i_in_data <= cell_queue.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver stall.
    always @(posedge i_clk) begin
        t_out_req want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (step_queue.size() == 0) begin
                    report_mismatch("unexpected result", o_out_data.min_step, 32'd0);
                end else begin
                    want = step_queue.pop_front();
                    if (o_out_data.min_step !== want.min_step)
                        report_mismatch("min_step", o_out_data.min_step, want.min_step);
                    if (o_out_data.sweep_done !== want.sweep_done)
                        report_mismatch("sweep_done", 32'(o_out_data.sweep_done),
                                        32'(want.sweep_done));
                end
            end
            if (recv_hold_left != 0) begin
                recv_hold_left <= recv_hold_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_INV_RE:    pred_inv_re = val;
            REG_USER_STEP: pred_user_step = val;
            REG_DIMS:      pred_dims = val[1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (cell_queue.size() != 0 || i_in_valid || step_queue.size() != 0)
            @(posedge i_clk);
        // Obstacle requests leave quickly but let the sequencer settle anyway.
        repeat (800) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_spacing();
        case ($urandom_range(3))
            0: return $urandom_range(32'h0001_0000, 32'h0000_4000);
            1: return $urandom_range(32'h0010_0000, 32'h0000_1000);
            2: return $urandom();
            default: return 32'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [31:0] rand_velocity();
        case ($urandom_range(4))
            0: return 32'd0;
            1: return $urandom();
            default: return 32'($signed($urandom_range(32'h0004_0000)) -
                                $signed(32'h0002_0000));
        endcase
    endfunction

    function automatic t_in_req rand_cell(input bit last);
        t_in_req c;
        c.velocity_x = rand_velocity();
        c.velocity_y = rand_velocity();
        c.velocity_z = rand_velocity();
        c.eddy_viscosity = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(32'h0000_2000);
        c.dx_size = rand_spacing();
        c.dy_size = rand_spacing();
        c.dz_size = rand_spacing();
        c.is_obstacle = ($urandom_range(7) == 0);
        c.sweep_last = last;
        return c;
    endfunction

    task automatic queue_sweeps(input int unsigned n);
        int unsigned len;
        while (n != 0) begin
            len = $urandom_range(12, 1);
            if (len > n) len = n;
            for (int unsigned k = 1; k <= len; k++)
                cell_queue.push_back(rand_cell(k == len || $urandom_range(19) == 0));
            n -= len;
        end
    endtask

    function automatic t_in_req make_cell(input logic [31:0] vx, vy, vz, vt, dx, dy, dz,
                                          input bit obst, input bit last);
        t_in_req c;
        c = '{vx, vy, vz, vt, dx, dy, dz, obst, last};
        return c;
    endfunction

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_INV_RE;
        i_cfg_data = '0;
        error_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold_left = 0;
        send_paused = 1'b0;
        pred_inv_re = 32'd655;
        pred_user_step = 32'd65536;
        pred_dims = 2'd2;
        pred_running_min = SAT32;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed cells under reset configuration: extremes and special cases.
        cell_queue.push_back(make_cell(0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000,
                                       32'h0001_0000, 0, 0));
        cell_queue.push_back(make_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                       32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                       32'hFFFF_FFFF, 0, 0));
        cell_queue.push_back(make_cell(32'h0001_0000, 0, 0, 0, 1, 1, 1, 0, 0));
        cell_queue.push_back(make_cell(32'hFFFF_FFFF, 32'h0000_0001, 1, 0, 32'hFFFF_FFFF,
                                       32'hFFFF_FFFF, 1, 0, 1));
        cell_queue.push_back(make_cell(32'h0002_0000, 32'h0002_0000, 0, 32'h0000_1000,
                                       32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 1, 0));
        cell_queue.push_back(make_cell(32'h0002_0000, 32'h0002_0000, 0, 32'h0000_1000,
                                       32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 1, 1));
        cell_queue.push_back(make_cell(0, 32'hFFFE_0000, 0, 32'h0001_0000,
                                       32'h0100_0000, 32'h0000_0100, 32'h0000_0100, 0, 1));
        wait_drained();

        // Zero viscosity and extreme user step, 3D rule.
        write_reg(REG_INV_RE, 32'd0);
        write_reg(REG_USER_STEP, 32'hFFFF_FFFF);
        write_reg(REG_DIMS, 2'd3);
        cell_queue.push_back(make_cell(0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                       32'hFFFF_FFFF, 0, 0));
        cell_queue.push_back(make_cell(32'h0001_0000, 32'h0001_0000, 32'h8000_0000, 0,
                                       32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 0, 0));
        cell_queue.push_back(make_cell(32'h0001_0000, 0, 32'h0000_0001, 32'h7FFF_FFFF,
                                       1, 32'h0000_0010, 32'hFFFF_FFFF, 0, 1));
        cell_queue.push_back(make_cell(32'h0000_8000, 32'h0000_8000, 0, 32'h0000_0100,
                                       32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0));
        cell_queue.push_back(make_cell(0, 0, 0, 0, 1, 1, 1, 1, 1));
        wait_drained();

        write_reg(REG_INV_RE, 32'hFFFF_FFFF);
        write_reg(REG_USER_STEP, 32'd0);
        write_reg(REG_DIMS, 2'd0);
        cell_queue.push_back(make_cell(0, 0, 0, 32'hFFFF_FFFF, 1, 1, 1, 0, 1));
        cell_queue.push_back(make_cell(32'h0001_0000, 32'h0001_0000, 0, 0,
                                       32'h0001_0000, 32'h0001_0000, 0, 0, 1));
        wait_drained();

        // Random phases with the three idle patterns and varied settings.
        for (int phase = 0; phase < 6; phase++) begin
            send_idle_pct = (phase < 2) ? 36 : (phase < 4) ? 72 : 0;
            recv_idle_pct = (phase < 2) ? 72 : (phase < 4) ? 36 : 0;
            write_reg(REG_INV_RE, ($urandom_range(1)) ? $urandom_range(32'h0000_1000) : $urandom());
            write_reg(REG_USER_STEP, $urandom());
            write_reg(REG_DIMS, 2'(phase + $urandom_range(1)));
            if (phase == 4) recv_hold_left = LONG_HOLD_CYCLES;
            queue_sweeps(80);
            if (phase == 5) begin
                while (cell_queue.size() > 40) @(posedge i_clk);
                // The sender pauses until every outstanding result has arrived.
                send_paused = 1'b1;
                while (i_in_valid || step_queue.size() != 0) @(posedge i_clk);
                send_paused = 1'b0;
            end
            wait_drained();
        end

        if (error_count == 0) begin
            $display("cfl_diffusion_timestep_min verification clean");
        end else begin
            $display("cfl_diffusion_timestep_min verification failed");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("cfl_diffusion_timestep_min verification failed");
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
hw/rtl/cfl_pkg.sv
hw/rtl/cfl_divider.sv
hw/rtl/cfl_mul32.sv
hw/rtl/cfl_diffusion_timestep_min.sv
hw/rtl/cfl_checker.sv
sim/cfl_diffusion_timestep_min_tb.sv
